FILE: sv/s256_pkg.sv
// Shared constants, types and the round constant table for the SHA-256 hasher.
`default_nettype none
package s256_pkg;

  localparam int HASH_WORDS  = 8;
  localparam int BLOCK_WORDS = 16;
  localparam int ROUNDS      = 64;

  localparam logic       OP_ABSORB  = 1'b0;
  localparam logic       OP_FINISH  = 1'b1;
  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [3:0] LEN_HI_IDX = 4'd14;
  localparam logic [3:0] LEN_LO_IDX = 4'd15;

  localparam logic [31:0] INIT_CHAIN [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic       rd_en;
    logic [3:0] rd_addr;
    logic [3:0] ld_idx;
    logic       busy;
    logic       done;
  } s256_ctl_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

FILE: sv/s256_ifs.sv
// Valid/ready channel interfaces for the hasher input and digest output.
`default_nettype none
interface s256_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface s256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        last_word;

  modport source (output valid, output digest_word, output last_word, input ready);
  modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface
`default_nettype wire

FILE: sv/s256_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module s256_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/s256_compress.sv
// SHA-256 compression engine: schedule window, one round per cycle, chaining words.
`default_nettype none
module s256_compress (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  chain_init,
  input  wire logic [31:0]           word_in,
  output      s256_pkg::s256_ctl_t   ctl,
  output      logic [31:0]           chain [s256_pkg::HASH_WORDS]
);

  localparam logic [6:0] SCHED_FIRST = 7'd1;
  localparam logic [6:0] LOAD_LAST   = 7'd16;
  localparam logic [6:0] SCHED_LAST  = 7'd64;
  localparam logic [6:0] ROUND_FIRST = 7'd2;
  localparam logic [6:0] ROUND_LAST  = 7'd65;
  localparam logic [6:0] FOLD_CYC    = 7'd66;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic        busy;
  logic [6:0]  cyc;
  logic [31:0] win [s256_pkg::BLOCK_WORDS];
  logic [31:0] wk;
  logic [31:0] v [s256_pkg::HASH_WORDS];

  logic [5:0]  t;
  logic        sched_on;
  logic        round_on;
  logic        fold;
  logic [31:0] w_new;
  logic [31:0] ssig0;
  logic [31:0] ssig1;
  logic [31:0] bsig0;
  logic [31:0] bsig1;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  assign t        = cyc[5:0] - 6'd1;
  assign sched_on = busy && (cyc >= SCHED_FIRST) && (cyc <= SCHED_LAST);
  assign round_on = busy && (cyc >= ROUND_FIRST) && (cyc <= ROUND_LAST);
  assign fold     = busy && (cyc == FOLD_CYC);

  always_comb begin
    ssig0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
    ssig1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
    w_new = (cyc <= LOAD_LAST) ? word_in : (ssig1 + win[9] + ssig0 + win[0]);
    bsig1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    bsig0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1    = v[7] + bsig1 + ch + wk;
    t2    = bsig0 + maj;
  end

  always_comb begin
    ctl.rd_en   = busy && (cyc < LOAD_LAST);
    ctl.rd_addr = cyc[3:0];
    ctl.ld_idx  = t[3:0];
    ctl.busy    = busy;
    ctl.done    = fold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cyc  <= '0;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        cyc  <= '0;
      end
    end else if (fold) begin
      busy <= 1'b0;
    end else begin
      cyc <= cyc + 7'd1;
    end
  end

  // schedule window and working variables
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      v <= chain;
    end else if (round_on) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
    if (sched_on) begin
      for (int i = 0; i < s256_pkg::BLOCK_WORDS - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[s256_pkg::BLOCK_WORDS-1] <= w_new;
      wk <= w_new + s256_pkg::round_k(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || chain_init) begin
      chain <= s256_pkg::INIT_CHAIN;
    end else if (fold) begin
      for (int i = 0; i < s256_pkg::HASH_WORDS; i++) begin
        chain[i] <= chain[i] + v[i];
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/sha256_stream_hasher_top.sv
// SHA-256 stream hasher top level: byte packing, padding control, digest output.
// The input accepts absorb words back to back while idle; the byte that completes a
// 64-byte block starts a compression that keeps the input stalled until it ends (one
// round per cycle, block words read from the block store RAM one per cycle). A finish
// word runs one or two compressions (two when 56 or more bytes of the last block are
// held), then presents the digest as eight 32-bit words, most significant byte first,
// the last flagged; the hasher then starts a new message.
`default_nettype none
module sha256_stream_hasher_top (
  input wire logic    clk,
  input wire logic    rst,
  s256_in_if.sink     item_in,
  s256_out_if.source  digest_out
);

  typedef enum logic [1:0] {ST_IDLE, ST_COMP, ST_EMIT} state_t;
  typedef enum logic [1:0] {MODE_NORMAL, MODE_PAD, MODE_EXTRA} mode_t;

  state_t      state;
  mode_t       mode;
  logic        comp_start;
  logic [5:0]  fill;
  logic [23:0] acc;
  logic [60:0] byte_count;
  logic [3:0]  pad_idx;
  logic [31:0] pad_word;
  logic        len_here;
  logic [2:0]  emit_idx;

  s256_pkg::s256_ctl_t ctl;
  logic [31:0] chain [s256_pkg::HASH_WORDS];
  logic [31:0] ram_rdata;
  logic [31:0] word_in;
  logic [31:0] pad_word_next;
  logic [63:0] msg_bits;
  logic        in_acc;
  logic        out_acc;
  logic        ram_we;
  logic        chain_init;

  assign item_in.ready          = (state == ST_IDLE);
  assign digest_out.valid       = (state == ST_EMIT);
  assign digest_out.digest_word = chain[emit_idx];
  assign digest_out.last_word   = (emit_idx == 3'd7);

  assign in_acc     = item_in.valid && item_in.ready;
  assign out_acc    = digest_out.valid && digest_out.ready;
  assign ram_we     = in_acc && (item_in.operation == s256_pkg::OP_ABSORB)
                      && (fill[1:0] == 2'd3);
  assign chain_init = out_acc && digest_out.last_word;
  assign msg_bits   = {byte_count, 3'b000};

  always_comb begin
    case (fill[1:0])
      2'd0:    pad_word_next = {s256_pkg::PAD_MARK, 24'h0};
      2'd1:    pad_word_next = {acc[7:0], s256_pkg::PAD_MARK, 16'h0};
      2'd2:    pad_word_next = {acc[15:0], s256_pkg::PAD_MARK, 8'h0};
      default: pad_word_next = {acc, s256_pkg::PAD_MARK};
    endcase
  end

  // block word source for the load phase of each compression
  always_comb begin
    case (mode)
      MODE_PAD: begin
        if (ctl.ld_idx < pad_idx) begin
          word_in = ram_rdata;
        end else if (ctl.ld_idx == pad_idx) begin
          word_in = pad_word;
        end else if (len_here && ctl.ld_idx == s256_pkg::LEN_HI_IDX) begin
          word_in = msg_bits[63:32];
        end else if (len_here && ctl.ld_idx == s256_pkg::LEN_LO_IDX) begin
          word_in = msg_bits[31:0];
        end else begin
          word_in = '0;
        end
      end
      MODE_EXTRA: begin
        if (ctl.ld_idx == s256_pkg::LEN_HI_IDX) begin
          word_in = msg_bits[63:32];
        end else if (ctl.ld_idx == s256_pkg::LEN_LO_IDX) begin
          word_in = msg_bits[31:0];
        end else begin
          word_in = '0;
        end
      end
      default: word_in = ram_rdata;
    endcase
  end

  s256_ram #(
    .WIDTH (32),
    .DEPTH (s256_pkg::BLOCK_WORDS)
  ) u_block_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill[5:2]),
    .wdata ({acc, item_in.data_byte}),
    .re    (ctl.rd_en),
    .raddr (ctl.rd_addr),
    .rdata (ram_rdata)
  );

  s256_compress u_compress (
    .clk        (clk),
    .rst        (rst),
    .start      (comp_start),
    .chain_init (chain_init),
    .word_in    (word_in),
    .ctl        (ctl),
    .chain      (chain)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mode       <= MODE_NORMAL;
      comp_start <= 1'b0;
      fill       <= '0;
      byte_count <= '0;
      emit_idx   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (item_in.operation == s256_pkg::OP_ABSORB) begin
              acc        <= {acc[15:0], item_in.data_byte};
              byte_count <= byte_count + 61'd1;
              fill       <= fill + 6'd1;
              if (fill == 6'd63) begin
                mode       <= MODE_NORMAL;
                comp_start <= 1'b1;
                state      <= ST_COMP;
              end
            end else begin
              pad_idx    <= fill[5:2];
              pad_word   <= pad_word_next;
              len_here   <= (fill[5:2] < s256_pkg::LEN_HI_IDX);
              mode       <= MODE_PAD;
              comp_start <= 1'b1;
              state      <= ST_COMP;
            end
          end
        end
        ST_COMP: begin
          comp_start <= 1'b0;
          if (ctl.done) begin
            case (mode)
              MODE_PAD: begin
                if (len_here) begin
                  emit_idx <= '0;
                  state    <= ST_EMIT;
                end else begin
                  mode       <= MODE_EXTRA;
                  comp_start <= 1'b1;
                end
              end
              MODE_EXTRA: begin
                emit_idx <= '0;
                state    <= ST_EMIT;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            emit_idx <= emit_idx + 3'd1;
            if (digest_out.last_word) begin
              fill       <= '0;
              byte_count <= '0;
              mode       <= MODE_NORMAL;
              state      <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    comp_start |-> !ctl.busy)
    else $error("compression started while engine busy");

  a_done_in_comp: assert property (@(posedge clk) disable iff (rst)
    ctl.done |-> state == ST_COMP)
    else $error("compression finished outside compress state");

  a_finish_pads: assert property (@(posedge clk) disable iff (rst)
    (in_acc && item_in.operation == s256_pkg::OP_FINISH) |=> (mode == MODE_PAD && comp_start))
    else $error("finish did not start a padded compression");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(item_in.ready && (digest_out.valid || ctl.busy)))
    else $error("input ready while hashing or emitting");
`endif

endmodule
`default_nettype wire

FILE: tb/sha256_stream_hasher_top_test.sv
// Self-checking testbench for the SHA-256 stream hasher: byte stream in, digest words out.
`default_nettype none
module sha256_stream_hasher_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_ITEMS  = 180;
  localparam int DIR_ROWS    = 12;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_CHAIN [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  typedef struct packed {
    logic [31:0] value;
    logic        is_last;
  } digest_exp_t;

  typedef struct {
    logic         op;
    logic [7:0]   data;
    bit           known;
    logic [255:0] digest;
  } stim_row_t;

  logic clk;
  logic rst;

  s256_in_if  byte_ch ();
  s256_out_if digest_ch ();

  sha256_stream_hasher_top dut (
    .clk(clk),
    .rst(rst),
    .item_in(byte_ch),
    .digest_out(digest_ch)
  );

  logic [31:0] chain_h [8];
  logic [7:0]  block_buf [64];
  int unsigned fill_bytes;
  logic [63:0] msg_bit_len;

  digest_exp_t pending_digest_words [$];
  int          mismatches;
  int          cycles;
  bit          steady;

  stim_row_t dir_table [DIR_ROWS] = '{
    '{s256_pkg::OP_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},
    '{s256_pkg::OP_ABSORB, 8'h61, 1'b0, '0},
    '{s256_pkg::OP_ABSORB, 8'h62, 1'b0, '0},
    '{s256_pkg::OP_ABSORB, 8'h63, 1'b0, '0},
    '{s256_pkg::OP_FINISH, 8'hff, 1'b1, ABC_DIGEST},
    '{s256_pkg::OP_FINISH, 8'hff, 1'b1, EMPTY_DIGEST},
    '{s256_pkg::OP_ABSORB, 8'h00, 1'b0, '0},
    '{s256_pkg::OP_ABSORB, 8'hff, 1'b0, '0},
    '{s256_pkg::OP_ABSORB, 8'h80, 1'b0, '0},
    '{s256_pkg::OP_FINISH, 8'h00, 1'b0, '0},
    '{s256_pkg::OP_ABSORB, 8'h7f, 1'b0, '0},
    '{s256_pkg::OP_FINISH, 8'h5a, 1'b0, '0}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] ror(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int r = 0; r < 16; r++)
      w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
    for (int r = 16; r < 64; r++) begin
      s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = s1 + w[r-7] + s0 + w[r-16];
    end
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (int r = 0; r < 64; r++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[r] + w[r];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endfunction

  function automatic void hash_absorb(input logic [7:0] b);
    block_buf[fill_bytes] = b;
    msg_bit_len += 64'd8;
    fill_bytes++;
    if (fill_bytes == 64) begin
      compress_block();
      fill_bytes = 0;
    end
  endfunction

  function automatic void hash_finish(output logic [31:0] words [8]);
    int unsigned pos;
    block_buf[fill_bytes] = 8'h80;
    pos = fill_bytes + 1;
    if (pos > 56) begin
      while (pos < 64) begin
        block_buf[pos] = 8'h00;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < 56) begin
      block_buf[pos] = 8'h00;
      pos++;
    end
    for (int k = 0; k < 8; k++)
      block_buf[56+k] = msg_bit_len[63-8*k -: 8];
    compress_block();
    words = chain_h;
    chain_h = START_CHAIN;
    fill_bytes = 0;
    msg_bit_len = '0;
  endfunction

  task automatic predict_word(input logic op, input logic [7:0] b, input bit known,
                              input logic [255:0] typed);
    logic [31:0] words [8];
    if (op == s256_pkg::OP_ABSORB) begin
      hash_absorb(b);
    end else begin
      hash_finish(words);
      for (int k = 0; k < s256_pkg::HASH_WORDS; k++)
        pending_digest_words.push_back('{known ? typed[255-32*k -: 32] : words[k],
                                         k == s256_pkg::HASH_WORDS - 1});
    end
  endtask

  // drive one word; called right after a rising edge
  task automatic send_word(input logic op, input logic [7:0] b, input bit known,
                           input logic [255:0] typed);
    while (!steady && $urandom_range(0, 99) < 26) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.operation <= op;
    byte_ch.data_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    predict_word(op, b, known, typed);
  endtask

  function automatic void report_bad(input string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    digest_exp_t exp_w;
    if (rst) begin
      digest_ch.ready <= 1'b0;
    end else begin
      if (digest_ch.valid && digest_ch.ready) begin
        if (pending_digest_words.size() == 0) begin
          report_bad($sformatf("unexpected digest word %h last %b",
                               digest_ch.digest_word, digest_ch.last_word));
        end else begin
          exp_w = pending_digest_words.pop_front();
          if (digest_ch.digest_word !== exp_w.value)
            report_bad($sformatf("digest_word mismatch: expected %h actual %h",
                                 exp_w.value, digest_ch.digest_word));
          if (digest_ch.last_word !== exp_w.is_last)
            report_bad($sformatf("last_word mismatch: expected %b actual %b",
                                 exp_w.is_last, digest_ch.last_word));
        end
      end
      digest_ch.ready <= steady || ($urandom_range(0, 99) >= 26);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sha256_stream_hasher_top verification failed");
      $finish;
    end
  end

  initial begin
    int rand_items;
    int rand_msgs;
    int msg_len;
    int sel;
    logic [31:0] boundary_lens [8];
    boundary_lens = '{55, 56, 57, 63, 64, 65, 119, 120};
    clk = 1'b0;
    rst = 1'b1;
    cycles = 0;
    mismatches = 0;
    steady = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.operation = s256_pkg::OP_ABSORB;
    byte_ch.data_byte = 8'h00;
    digest_ch.ready = 1'b0;
    chain_h = START_CHAIN;
    fill_bytes = 0;
    msg_bit_len = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      send_word(dir_table[i].op, dir_table[i].data, dir_table[i].known, dir_table[i].digest);

    rand_items = 0;
    rand_msgs = 0;
    while (rand_items < RAND_ITEMS || rand_msgs < 6) begin
      sel = $urandom_range(0, 9);
      if (sel < 5)
        msg_len = $urandom_range(0, 10);
      else if (sel < 7)
        msg_len = $urandom_range(11, 54);
      else
        msg_len = boundary_lens[$urandom_range(0, 7)];
      for (int j = 0; j <= msg_len; j++) begin
        steady = (rand_items >= 60 && rand_items < 120);
        if (j < msg_len)
          send_word(s256_pkg::OP_ABSORB, 8'($urandom_range(0, 255)), 1'b0, '0);
        else
          send_word(s256_pkg::OP_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
        rand_items++;
      end
      rand_msgs++;
    end
    steady = 1'b0;
    byte_ch.valid <= 1'b0;

    while (pending_digest_words.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    if (mismatches == 0 && pending_digest_words.size() == 0)
      $display("sha256_stream_hasher_top verification clean");
    else
      $display("sha256_stream_hasher_top verification failed");
    $finish;
  end

endmodule
`default_nettype wire
